FILE: rtl/core/frp_pkg.sv
// shared types, codes and default sizes of the fragment reassembly pool
package frp_pkg;

  localparam int unsigned SLOTS_DEF      = 4;
  localparam int unsigned MAX_FRAGS_DEF  = 8;
  localparam int unsigned FRAG_BYTES_DEF = 64;
  localparam logic [31:0] TIMEOUT_RESET  = 32'd30000;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned SLOT_IDX_W = 4;
  localparam int unsigned TOTAL_W    = 5;

  localparam logic [1:0] REQ_FRAG    = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_CLR_ONE = 2'd2;
  localparam logic [1:0] REQ_CLR_ALL = 2'd3;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CONT  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] OUT_STATUS = 2'd0;
  localparam logic [1:0] OUT_DATA   = 2'd1;
  localparam logic [1:0] OUT_TMO    = 2'd2;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_DUP      = 4'd1;
  localparam logic [3:0] ST_BAD_HDR  = 4'd2;
  localparam logic [3:0] ST_NO_START = 4'd3;
  localparam logic [3:0] ST_TOO_MANY = 4'd4;
  localparam logic [3:0] ST_POOL     = 4'd5;
  localparam logic [3:0] ST_TOTAL    = 4'd6;
  localparam logic [3:0] ST_SEQ      = 4'd7;
  localparam logic [3:0] ST_LARGE    = 4'd8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] peer_id;
    logic        header_ok;
    logic [1:0]  frag_kind;
    logic [15:0] sequence_req;
    logic [15:0] total_frags;
    logic [15:0] payload_len;
    logic        word_first;
    logic        word_last;
    logic [63:0] payload_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [3:0]  status_code;
    logic [15:0] peer_out;
    logic [63:0] data_out;
    logic [3:0]  byte_count;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic                  do_status;
    logic [3:0]            status;
    logic                  do_drain;
    logic                  do_tmo;
    logic                  tmo_last;
    logic [15:0]           peer;
    logic [SLOT_IDX_W-1:0] slot;
    logic [TOTAL_W-1:0]    total;
  } cmd_t;

endpackage

FILE: rtl/core/fragment_reassembly_pool.sv
// top level of the fragment reassembly pool
// Items enter on a queue-style port: an item is taken when push is high and full
// is low. Fragment words, ticks and clears share that port. Results leave the same
// way: the oldest result sits on result_o while empty is low and goes at pop.
// The timeout register is written over cfg_valid_i/cfg_data_i; cfg_ready_o is
// always high. A front end handles each item in the cycle it is taken, updates
// the session table and payload memory, and queues at most one command in a
// two-entry queue; a back end turns commands into results through a one-entry
// output register. With a free command queue and no drain or timeout notices
// pending, a fragment word is taken every cycle; the back end fetches a command,
// then emits its results, before it takes the next one.
// A packet drain reads each fragment's length, then reads each data word from
// payload memory and emits it; items are held off while a drain is pending. A
// tick holds items off while notices for its expired sessions are queued.
// When the receiver stops popping, results back up into the queue and full rises.
// Reset empties the pool, clears tick time and sets the timeout to 30000; the
// memories are not cleared, since no entry is read before it is written.
module fragment_reassembly_pool #(
  parameter int unsigned SLOTS      = frp_pkg::SLOTS_DEF,
  parameter int unsigned MAX_FRAGS  = frp_pkg::MAX_FRAGS_DEF,
  parameter int unsigned FRAG_BYTES = frp_pkg::FRAG_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  frp_pkg::in_item_t  item_i,
  input  logic               pop,
  output logic               empty,
  output frp_pkg::out_item_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned WPF   = (FRAG_BYTES + 7) / 8;
  localparam int unsigned CELLS = SLOTS * MAX_FRAGS;
  localparam int unsigned PDEP  = CELLS * WPF;
  localparam int unsigned CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned PAW   = (PDEP > 1) ? $clog2(PDEP) : 1;
  localparam int unsigned LW    = $clog2(FRAG_BYTES + 1);

  logic          cmd_push, cmd_full, cmd_pop, cmd_empty, drain_done;
  frp_pkg::cmd_t cmd_in, cmd_out;
  logic          pay_we, pay_re, len_we, len_re;
  logic [PAW-1:0] pay_waddr, pay_raddr;
  logic [63:0]   pay_wdata, pay_rdata;
  logic [CAW-1:0] len_waddr, len_raddr;
  logic [LW-1:0] len_wdata, len_rdata;

  frp_front #(
    .SLOTS(SLOTS), .MAX_FRAGS(MAX_FRAGS), .FRAG_BYTES(FRAG_BYTES)
  ) u_front (
    .clk_i, .rst_ni, .push, .full, .item_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .cmd_push_o(cmd_push), .cmd_o(cmd_in), .cmd_full_i(cmd_full),
    .drain_done_i(drain_done),
    .pay_we_o(pay_we), .pay_waddr_o(pay_waddr), .pay_wdata_o(pay_wdata),
    .len_we_o(len_we), .len_waddr_o(len_waddr), .len_wdata_o(len_wdata)
  );

  frp_cmd_fifo u_cmdq (
    .clk_i, .rst_ni,
    .push_i(cmd_push), .cmd_i(cmd_in), .full_o(cmd_full),
    .pop_i(cmd_pop), .empty_o(cmd_empty), .cmd_o(cmd_out)
  );

  frp_ram #(.WIDTH(64), .DEPTH(PDEP)) u_pay_ram (
    .clk_i, .we_i(pay_we), .waddr_i(pay_waddr), .wdata_i(pay_wdata),
    .re_i(pay_re), .raddr_i(pay_raddr), .rdata_o(pay_rdata)
  );

  frp_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_len_ram (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .re_i(len_re), .raddr_i(len_raddr), .rdata_o(len_rdata)
  );

  frp_back #(
    .SLOTS(SLOTS), .MAX_FRAGS(MAX_FRAGS), .FRAG_BYTES(FRAG_BYTES)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_empty_i(cmd_empty), .cmd_i(cmd_out), .cmd_pop_o(cmd_pop),
    .drain_done_o(drain_done),
    .pay_re_o(pay_re), .pay_raddr_o(pay_raddr), .pay_rdata_i(pay_rdata),
    .len_re_o(len_re), .len_raddr_o(len_raddr), .len_rdata_i(len_rdata),
    .empty, .pop, .result_o
  );

endmodule

FILE: rtl/core/frp_ram.sv
// generic one-write one-read ram with registered read
module frp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/frp_cmd_fifo.sv
// short command queue between the front and the back
module frp_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  frp_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output frp_pkg::cmd_t cmd_o
);

  localparam int unsigned PW = (frp_pkg::CMD_DEPTH > 1) ? $clog2(frp_pkg::CMD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(frp_pkg::CMD_DEPTH + 1);

  frp_pkg::cmd_t  mem_q [frp_pkg::CMD_DEPTH];
  logic [PW-1:0]  wp_q, rp_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(frp_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(frp_pkg::CMD_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(frp_pkg::CMD_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

FILE: rtl/core/frp_front.sv
// front end: accepts items, keeps session state, stores payload, issues commands
module frp_front #(
  parameter int unsigned SLOTS      = frp_pkg::SLOTS_DEF,
  parameter int unsigned MAX_FRAGS  = frp_pkg::MAX_FRAGS_DEF,
  parameter int unsigned FRAG_BYTES = frp_pkg::FRAG_BYTES_DEF,
  localparam int unsigned WPF   = (FRAG_BYTES + 7) / 8,
  localparam int unsigned CELLS = SLOTS * MAX_FRAGS,
  localparam int unsigned PDEP  = CELLS * WPF,
  localparam int unsigned CAW   = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int unsigned PAW   = (PDEP > 1) ? $clog2(PDEP) : 1,
  localparam int unsigned LW    = $clog2(FRAG_BYTES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  frp_pkg::in_item_t   item_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  output logic                cmd_push_o,
  output frp_pkg::cmd_t       cmd_o,
  input  logic                cmd_full_i,
  input  logic                drain_done_i,
  output logic                pay_we_o,
  output logic [PAW-1:0]      pay_waddr_o,
  output logic [63:0]         pay_wdata_o,
  output logic                len_we_o,
  output logic [CAW-1:0]      len_waddr_o,
  output logic [LW-1:0]       len_wdata_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int unsigned TW = $clog2(MAX_FRAGS + 1);
  localparam int unsigned WW = $clog2(WPF + 1);

  logic [SLOTS-1:0]     busy_q, busy_d;
  logic [15:0]          peer_q [SLOTS];
  logic [15:0]          peer_d [SLOTS];
  logic [TW-1:0]        total_q [SLOTS];
  logic [TW-1:0]        total_d [SLOTS];
  logic [TW-1:0]        got_q [SLOTS];
  logic [TW-1:0]        got_d [SLOTS];
  logic [31:0]          started_q [SLOTS];
  logic [31:0]          started_d [SLOTS];
  logic [MAX_FRAGS-1:0] seen_q [SLOTS];
  logic [MAX_FRAGS-1:0] seen_d [SLOTS];
  logic [31:0]          tick_q, tick_d, tmo_q, tmo_d;
  logic                 cx_act_q, cx_act_d;
  logic [SW-1:0]        cx_slot_q, cx_slot_d;
  logic [QW-1:0]        cx_seq_q, cx_seq_d;
  logic [LW-1:0]        cx_len_q, cx_len_d;
  logic [WW-1:0]        cx_words_q, cx_words_d;
  logic                 scan_q, scan_d, drain_busy_q, drain_busy_d;
  logic [SLOTS-1:0]     mask_q, mask_d;
  logic                 accept;

  assign full        = cmd_full_i || scan_q || drain_busy_q;
  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [SLOTS-1:0] hit, freev, lowm;
    logic             hit_any, free_any, have, do_open, e_act, last_cmd;
    logic [SW-1:0]    hit_idx, free_idx, sl, sc_idx;
    logic [3:0]       st;
    logic [LW:0]      need;
    logic [WW+3:0]    gotb;
    logic [CAW-1:0]   cell_idx;

    busy_d = busy_q;
    peer_d = peer_q;
    total_d = total_q;
    got_d = got_q;
    started_d = started_q;
    seen_d = seen_q;
    tick_d = tick_q;
    tmo_d = tmo_q;
    cx_act_d = cx_act_q;
    cx_slot_d = cx_slot_q;
    cx_seq_d = cx_seq_q;
    cx_len_d = cx_len_q;
    cx_words_d = cx_words_q;
    scan_d = scan_q;
    mask_d = mask_q;
    drain_busy_d = drain_busy_q && !drain_done_i;
    cmd_push_o = 1'b0;
    cmd_o = '0;
    pay_we_o = 1'b0;
    pay_waddr_o = '0;
    pay_wdata_o = item_i.payload_word;
    len_we_o = 1'b0;
    len_waddr_o = '0;
    len_wdata_o = '0;
    st = frp_pkg::ST_OK;
    have = 1'b0;
    do_open = 1'b0;
    sl = '0;
    e_act = 1'b0;
    lowm = '0;
    last_cmd = 1'b0;
    sc_idx = '0;
    need = '0;
    gotb = '0;
    cell_idx = '0;

    if (cfg_valid_i) begin
      tmo_d = cfg_data_i;
    end

    for (int s = 0; s < SLOTS; s++) begin
      hit[s] = busy_q[s] && (peer_q[s] == item_i.peer_id);
    end
    hit_any = |hit;
    hit_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (hit[s]) begin
        hit_idx = SW'(s);
      end
    end
    freev = ~busy_q;
    if (item_i.frag_kind == frp_pkg::KIND_START && hit_any) begin
      freev[hit_idx] = 1'b1;
    end
    free_any = |freev;
    free_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (freev[s]) begin
        free_idx = SW'(s);
      end
    end

    // timeout notices, one per cycle while the command queue is not full
    if (scan_q && !cmd_full_i) begin
      for (int s = SLOTS - 1; s >= 0; s--) begin
        if (mask_q[s]) begin
          sc_idx = SW'(s);
        end
      end
      lowm = '0;
      lowm[sc_idx] = 1'b1;
      last_cmd = ((mask_q & ~lowm) == '0);
      mask_d = mask_q & ~lowm;
      scan_d = !last_cmd;
      cmd_push_o = 1'b1;
      cmd_o.do_tmo = 1'b1;
      cmd_o.tmo_last = last_cmd;
      cmd_o.peer = peer_q[sc_idx];
    end

    if (accept) begin
      case (item_i.req_type)
        frp_pkg::REQ_TICK: begin
          tick_d = tick_q + 32'd1;
          for (int s = 0; s < SLOTS; s++) begin
            mask_d[s] = busy_q[s] && ((tick_d - started_q[s]) > tmo_q);
            if (mask_d[s]) begin
              busy_d[s] = 1'b0;
              got_d[s] = '0;
              total_d[s] = '0;
              seen_d[s] = '0;
              if (cx_act_q && cx_slot_q == SW'(s)) begin
                cx_act_d = 1'b0;
              end
            end
          end
          scan_d = |mask_d;
        end
        frp_pkg::REQ_CLR_ONE: begin
          if (hit_any) begin
            busy_d[hit_idx] = 1'b0;
            got_d[hit_idx] = '0;
            total_d[hit_idx] = '0;
            seen_d[hit_idx] = '0;
            if (cx_act_q && cx_slot_q == hit_idx) begin
              cx_act_d = 1'b0;
            end
          end
        end
        frp_pkg::REQ_CLR_ALL: begin
          for (int s = 0; s < SLOTS; s++) begin
            busy_d[s] = 1'b0;
            got_d[s] = '0;
            total_d[s] = '0;
            seen_d[s] = '0;
          end
          cx_act_d = 1'b0;
        end
        default: begin
          if (item_i.word_first) begin
            cx_act_d = 1'b0;
            if (!item_i.header_ok || item_i.frag_kind > frp_pkg::KIND_END) begin
              st = frp_pkg::ST_BAD_HDR;
            end else if (item_i.frag_kind == frp_pkg::KIND_START) begin
              if (hit_any) begin
                busy_d[hit_idx] = 1'b0;
                got_d[hit_idx] = '0;
                total_d[hit_idx] = '0;
                seen_d[hit_idx] = '0;
              end
              do_open = 1'b1;
            end else if (hit_any) begin
              sl = hit_idx;
              have = 1'b1;
            end else if (item_i.frag_kind == frp_pkg::KIND_END &&
                         item_i.total_frags == 16'd1 && item_i.sequence_req == 16'd0) begin
              do_open = 1'b1;
            end else begin
              st = frp_pkg::ST_NO_START;
            end
            if (do_open) begin
              if (item_i.total_frags > 16'(MAX_FRAGS)) begin
                st = frp_pkg::ST_TOO_MANY;
              end else if (!free_any) begin
                st = frp_pkg::ST_POOL;
              end else begin
                busy_d[free_idx] = 1'b1;
                peer_d[free_idx] = item_i.peer_id;
                total_d[free_idx] = TW'(item_i.total_frags);
                got_d[free_idx] = '0;
                started_d[free_idx] = tick_q;
                seen_d[free_idx] = '0;
                sl = free_idx;
                have = 1'b1;
              end
            end
            if (have) begin
              if (item_i.total_frags != 16'(total_d[sl])) begin
                st = frp_pkg::ST_TOTAL;
              end else if (item_i.sequence_req >= 16'(total_d[sl])) begin
                st = frp_pkg::ST_SEQ;
              end else if (seen_d[sl][item_i.sequence_req[QW-1:0]]) begin
                st = frp_pkg::ST_DUP;
              end else if (item_i.payload_len > 16'(FRAG_BYTES)) begin
                st = frp_pkg::ST_LARGE;
              end else begin
                cx_act_d = 1'b1;
                cx_slot_d = sl;
                cx_seq_d = item_i.sequence_req[QW-1:0];
                cx_len_d = item_i.payload_len[LW-1:0];
                cx_words_d = '0;
              end
            end
            cmd_push_o = 1'b1;
            cmd_o.do_status = 1'b1;
            cmd_o.status = st;
            cmd_o.peer = item_i.peer_id;
            e_act = cx_act_d;
          end else begin
            e_act = cx_act_q;
          end

          // payload word into the active fragment
          if (e_act) begin
            cell_idx = CAW'(cx_slot_d) * CAW'(MAX_FRAGS) + CAW'(cx_seq_d);
            need = ((LW + 1)'(cx_len_d) + (LW + 1)'(7)) >> 3;
            if ((LW + 1)'(cx_words_d) < need && cx_words_d < WW'(WPF)) begin
              pay_we_o = 1'b1;
              pay_waddr_o = PAW'(cell_idx) * PAW'(WPF) + PAW'(cx_words_d);
              cx_words_d = cx_words_d + 1'b1;
            end
            if (item_i.word_last) begin
              gotb = (WW + 4)'(cx_words_d) << 3;
              len_we_o = 1'b1;
              len_waddr_o = cell_idx;
              len_wdata_o = ((WW + 4)'(cx_len_d) < gotb) ? cx_len_d : LW'(gotb);
              seen_d[cx_slot_d][cx_seq_d] = 1'b1;
              got_d[cx_slot_d] = got_d[cx_slot_d] + 1'b1;
              cx_act_d = 1'b0;
              if (got_d[cx_slot_d] == total_d[cx_slot_d]) begin
                cmd_push_o = 1'b1;
                cmd_o.do_drain = 1'b1;
                cmd_o.peer = peer_d[cx_slot_d];
                cmd_o.slot = frp_pkg::SLOT_IDX_W'(cx_slot_d);
                cmd_o.total = frp_pkg::TOTAL_W'(total_d[cx_slot_d]);
                drain_busy_d = 1'b1;
                busy_d[cx_slot_d] = 1'b0;
                got_d[cx_slot_d] = '0;
                total_d[cx_slot_d] = '0;
                seen_d[cx_slot_d] = '0;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    peer_q <= peer_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        total_q[s] <= '0;
        got_q[s] <= '0;
        started_q[s] <= '0;
        seen_q[s] <= '0;
      end
      tick_q <= '0;
      tmo_q <= frp_pkg::TIMEOUT_RESET;
      cx_act_q <= 1'b0;
      cx_slot_q <= '0;
      cx_seq_q <= '0;
      cx_len_q <= '0;
      cx_words_q <= '0;
      scan_q <= 1'b0;
      mask_q <= '0;
      drain_busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      total_q <= total_d;
      got_q <= got_d;
      started_q <= started_d;
      seen_q <= seen_d;
      tick_q <= tick_d;
      tmo_q <= tmo_d;
      cx_act_q <= cx_act_d;
      cx_slot_q <= cx_slot_d;
      cx_seq_q <= cx_seq_d;
      cx_len_q <= cx_len_d;
      cx_words_q <= cx_words_d;
      scan_q <= scan_d;
      mask_q <= mask_d;
      drain_busy_q <= drain_busy_d;
    end
  end

endmodule

FILE: rtl/core/frp_back.sv
// back end: turns commands into result items and drains finished packets
module frp_back #(
  parameter int unsigned SLOTS      = frp_pkg::SLOTS_DEF,
  parameter int unsigned MAX_FRAGS  = frp_pkg::MAX_FRAGS_DEF,
  parameter int unsigned FRAG_BYTES = frp_pkg::FRAG_BYTES_DEF,
  localparam int unsigned WPF   = (FRAG_BYTES + 7) / 8,
  localparam int unsigned CELLS = SLOTS * MAX_FRAGS,
  localparam int unsigned PDEP  = CELLS * WPF,
  localparam int unsigned CAW   = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int unsigned PAW   = (PDEP > 1) ? $clog2(PDEP) : 1,
  localparam int unsigned LW    = $clog2(FRAG_BYTES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  frp_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               drain_done_o,
  output logic               pay_re_o,
  output logic [PAW-1:0]     pay_raddr_o,
  input  logic [63:0]        pay_rdata_i,
  output logic               len_re_o,
  output logic [CAW-1:0]     len_raddr_o,
  input  logic [LW-1:0]      len_rdata_i,
  output logic               empty,
  input  logic               pop,
  output frp_pkg::out_item_t result_o
);

  localparam int unsigned TW = $clog2(MAX_FRAGS + 1);
  localparam int unsigned WW = $clog2(WPF + 1);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_STAT = 3'd1;
  localparam logic [2:0] B_RDB  = 3'd2;
  localparam logic [2:0] B_WB   = 3'd3;
  localparam logic [2:0] B_RDW  = 3'd4;
  localparam logic [2:0] B_EMW  = 3'd5;
  localparam logic [2:0] B_FIN  = 3'd6;
  localparam logic [2:0] B_TMO  = 3'd7;

  logic [2:0]         st_q, st_d;
  frp_pkg::cmd_t      cmd_q, cmd_d;
  logic [TW-1:0]      q_q, q_d;
  logic [WW-1:0]      w_q, w_d;
  logic [LW-1:0]      left_q, left_d;
  logic               hold_v_q, hold_v_d;
  logic [63:0]        hold_data_q, hold_data_d;
  logic [3:0]         hold_bc_q, hold_bc_d;
  logic               out_v_q;
  frp_pkg::out_item_t out_q, emit_item;
  logic               emit, out_free;
  logic [CAW-1:0]     cell_idx;

  assign out_free = !out_v_q || pop;
  assign empty    = !out_v_q;
  assign result_o = out_q;
  assign cell_idx = CAW'(cmd_q.slot) * CAW'(MAX_FRAGS) + CAW'(q_q);

  always_comb begin
    logic [2:0] nxt;

    st_d = st_q;
    cmd_d = cmd_q;
    q_d = q_q;
    w_d = w_q;
    left_d = left_q;
    hold_v_d = hold_v_q;
    hold_data_d = hold_data_q;
    hold_bc_d = hold_bc_q;
    emit = 1'b0;
    emit_item = '0;
    emit_item.peer_out = cmd_q.peer;
    cmd_pop_o = 1'b0;
    drain_done_o = 1'b0;
    pay_re_o = 1'b0;
    pay_raddr_o = PAW'(cell_idx) * PAW'(WPF) + PAW'(w_q);
    len_re_o = 1'b0;
    len_raddr_o = cell_idx;
    nxt = cmd_q.do_drain ? B_RDB : (cmd_q.do_tmo ? B_TMO : B_IDLE);

    case (st_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_d = cmd_i;
          cmd_pop_o = 1'b1;
          st_d = B_STAT;
        end
      end
      B_STAT: begin
        if (!cmd_q.do_status || out_free) begin
          if (cmd_q.do_status) begin
            emit = 1'b1;
            emit_item.out_kind = frp_pkg::OUT_STATUS;
            emit_item.status_code = cmd_q.status;
            emit_item.last_out = 1'b1;
          end
          q_d = '0;
          hold_v_d = 1'b0;
          st_d = nxt;
        end
      end
      B_RDB: begin
        if (q_q == TW'(cmd_q.total)) begin
          st_d = B_FIN;
        end else begin
          len_re_o = 1'b1;
          st_d = B_WB;
        end
      end
      B_WB: begin
        left_d = len_rdata_i;
        w_d = '0;
        st_d = B_RDW;
      end
      B_RDW: begin
        if (left_q == '0) begin
          q_d = q_q + 1'b1;
          st_d = B_RDB;
        end else begin
          pay_re_o = 1'b1;
          st_d = B_EMW;
        end
      end
      B_EMW: begin
        if (!hold_v_q || out_free) begin
          if (hold_v_q) begin
            emit = 1'b1;
            emit_item.out_kind = frp_pkg::OUT_DATA;
            emit_item.data_out = hold_data_q;
            emit_item.byte_count = hold_bc_q;
          end
          hold_v_d = 1'b1;
          hold_data_d = pay_rdata_i;
          hold_bc_d = (left_q > LW'(8)) ? 4'd8 : 4'(left_q);
          left_d = (left_q > LW'(8)) ? left_q - LW'(8) : '0;
          w_d = w_q + 1'b1;
          st_d = B_RDW;
        end
      end
      B_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.out_kind = frp_pkg::OUT_DATA;
          emit_item.data_out = hold_v_q ? hold_data_q : 64'd0;
          emit_item.byte_count = hold_v_q ? hold_bc_q : 4'd0;
          emit_item.last_out = 1'b1;
          hold_v_d = 1'b0;
          drain_done_o = 1'b1;
          st_d = B_IDLE;
        end
      end
      B_TMO: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.out_kind = frp_pkg::OUT_TMO;
          emit_item.last_out = cmd_q.tmo_last;
          st_d = B_IDLE;
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    w_q <= w_d;
    left_q <= left_d;
    hold_data_q <= hold_data_d;
    hold_bc_q <= hold_bc_d;
    if (emit) begin
      out_q <= emit_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      q_q <= '0;
      hold_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      q_q <= q_d;
      hold_v_q <= hold_v_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

endmodule

FILE: test/tb_fragment_reassembly_pool.sv
// testbench for the fragment reassembly pool: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_fragment_reassembly_pool;
  import frp_pkg::*;

  localparam int unsigned NSLOT = SLOTS_DEF;
  localparam int unsigned NFRAG = MAX_FRAGS_DEF;
  localparam int unsigned FBYTES = FRAG_BYTES_DEF;
  localparam int unsigned WPF = (FBYTES + 7) / 8;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t item_i = '0;
  logic pop = 1'b0;
  logic empty;
  out_item_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  fragment_reassembly_pool dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .item_i(item_i),
    .pop(pop), .empty(empty), .result_o(result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [31:0] timeout_q;
  logic sess_busy [NSLOT];
  logic [15:0] sess_peer [NSLOT];
  int unsigned sess_total [NSLOT];
  int unsigned sess_got [NSLOT];
  logic [31:0] sess_start [NSLOT];
  logic [15:0] sess_seen [NSLOT];
  int unsigned cell_bytes [NSLOT*NFRAG];
  logic [63:0] word_mem [NSLOT*NFRAG*WPF];
  logic [31:0] tick_q;
  logic asm_active;
  int unsigned asm_slot, asm_seq, asm_len, asm_words;

  out_item_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic gaps_on = 1'b1;
  logic hold_req = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fragment_reassembly_pool");
      $finish;
    end
  end

  function automatic void emit(logic [1:0] kind, logic [3:0] st, logic [15:0] peer,
                               logic [63:0] data, logic [3:0] bytes, logic last);
    out_item_t r;
    r.out_kind = kind;
    r.status_code = st;
    r.peer_out = peer;
    r.data_out = data;
    r.byte_count = bytes;
    r.last_out = last;
    expected_q.push_back(r);
  endfunction

  function automatic void sess_free(int unsigned s);
    sess_busy[s] = 1'b0;
    sess_got[s] = 0;
    sess_total[s] = 0;
    sess_seen[s] = '0;
    if (asm_active && asm_slot == s) asm_active = 1'b0;
  endfunction

  function automatic int sess_find(logic [15:0] peer);
    for (int s = 0; s < NSLOT; s++) begin
      if (sess_busy[s] && sess_peer[s] == peer) return s;
    end
    return -1;
  endfunction

  function automatic logic [3:0] sess_open(logic [15:0] peer, int unsigned total,
                                           output int slot);
    if (total > NFRAG) return ST_TOO_MANY;
    for (int s = 0; s < NSLOT; s++) begin
      if (!sess_busy[s]) begin
        sess_busy[s] = 1'b1;
        sess_peer[s] = peer;
        sess_total[s] = total;
        sess_got[s] = 0;
        sess_start[s] = tick_q;
        sess_seen[s] = '0;
        slot = s;
        return ST_OK;
      end
    end
    return ST_POOL;
  endfunction

  function automatic void packet_drain(int unsigned s);
    int unsigned cnt;
    int unsigned cell_idx;
    int unsigned left;
    cnt = 0;
    for (int unsigned q = 0; q < sess_total[s] && q < NFRAG; q++) begin
      cell_idx = s * NFRAG + q;
      for (int unsigned w = 0; w * 8 < cell_bytes[cell_idx] && w < WPF; w++) begin
        left = cell_bytes[cell_idx] - w * 8;
        emit(OUT_DATA, ST_OK, sess_peer[s], word_mem[cell_idx*WPF + w],
             (left > 8) ? 4'd8 : 4'(left), 1'b0);
        cnt++;
      end
    end
    if (cnt == 0) emit(OUT_DATA, ST_OK, sess_peer[s], '0, '0, 1'b1);
    else expected_q[expected_q.size()-1].last_out = 1'b1;
  endfunction

  function automatic void frag_word(logic [63:0] word, logic last);
    int unsigned cell_idx;
    int unsigned need;
    int unsigned got;
    cell_idx = asm_slot * NFRAG + asm_seq;
    need = (asm_len + 7) / 8;
    if (asm_words < need && asm_words < WPF) begin
      word_mem[cell_idx*WPF + asm_words] = word;
      asm_words++;
    end
    if (!last) return;
    got = asm_words * 8;
    cell_bytes[cell_idx] = (asm_len < got) ? asm_len : got;
    sess_seen[asm_slot] = sess_seen[asm_slot] | (16'd1 << asm_seq);
    sess_got[asm_slot]++;
    asm_active = 1'b0;
    if (sess_got[asm_slot] == sess_total[asm_slot]) begin
      packet_drain(asm_slot);
      sess_free(asm_slot);
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    int s;
    int e;
    int unsigned n;
    logic [3:0] st;
    case (it.req_type)
      REQ_TICK: begin
        tick_q = tick_q + 32'd1;
        n = 0;
        for (int k = 0; k < NSLOT; k++) begin
          if (sess_busy[k] && (tick_q - sess_start[k]) > timeout_q) begin
            emit(OUT_TMO, ST_OK, sess_peer[k], '0, '0, 1'b0);
            sess_free(k);
            n++;
          end
        end
        if (n > 0) expected_q[expected_q.size()-1].last_out = 1'b1;
      end
      REQ_CLR_ONE: begin
        s = sess_find(it.peer_id);
        if (s >= 0) sess_free(s);
      end
      REQ_CLR_ALL: begin
        for (int k = 0; k < NSLOT; k++) sess_free(k);
        asm_active = 1'b0;
      end
      default: begin
        if (!it.word_first) begin
          if (asm_active) frag_word(it.payload_word, it.word_last);
        end else begin
          asm_active = 1'b0;
          s = -1;
          if (!it.header_ok || it.frag_kind > KIND_END) begin
            st = ST_BAD_HDR;
          end else begin
            st = ST_OK;
            if (it.frag_kind == KIND_START) begin
              e = sess_find(it.peer_id);
              if (e >= 0) sess_free(e);
              st = sess_open(it.peer_id, it.total_frags, s);
            end else begin
              s = sess_find(it.peer_id);
              if (s < 0) begin
                if (it.frag_kind == KIND_END && it.total_frags == 1 && it.sequence_req == 0)
                  st = sess_open(it.peer_id, it.total_frags, s);
                else
                  st = ST_NO_START;
              end
            end
            if (st == ST_OK && s >= 0) begin
              if (it.total_frags != sess_total[s]) st = ST_TOTAL;
              else if (it.sequence_req >= sess_total[s]) st = ST_SEQ;
              else if (sess_seen[s][it.sequence_req]) st = ST_DUP;
              else if (it.payload_len > FBYTES) st = ST_LARGE;
              else begin
                asm_active = 1'b1;
                asm_slot = s;
                asm_seq = it.sequence_req;
                asm_len = it.payload_len;
                asm_words = 0;
              end
            end
          end
          emit(OUT_STATUS, st, it.peer_id, '0, '0, 1'b1);
          if (asm_active) frag_word(it.payload_word, it.word_last);
        end
      end
    endcase
  endfunction

  // result side
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 14) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        want = expected_q.pop_front();
        if (result_o.out_kind !== want.out_kind || result_o.status_code !== want.status_code ||
            result_o.peer_out !== want.peer_out || result_o.data_out !== want.data_out ||
            result_o.byte_count !== want.byte_count || result_o.last_out !== want.last_out) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, result_o);
        end
      end
    end
  end

  // input side
  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    predict_item(it);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
    end
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic send_frag(logic [15:0] peer, logic [1:0] kind, int unsigned seq,
                           int unsigned total, int unsigned len, int unsigned nwords,
                           logic hdr_ok = 1'b1, logic drop_last = 1'b0);
    in_item_t it;
    for (int unsigned w = 0; w < nwords; w++) begin
      it = noise_item();
      it.req_type = REQ_FRAG;
      it.word_first = (w == 0);
      it.word_last = (w == nwords - 1) && !drop_last;
      if (w == 0) begin
        it.peer_id = peer;
        it.header_ok = hdr_ok;
        it.frag_kind = kind;
        it.sequence_req = seq;
        it.total_frags = total;
        it.payload_len = len;
      end
      send_item(it);
    end
  endtask

  task automatic send_req(logic [1:0] req, logic [15:0] peer);
    in_item_t it;
    it = noise_item();
    it.req_type = req;
    it.peer_id = peer;
    send_item(it);
  endtask

  task automatic drain_all();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [31:0] value);
    drain_all();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    timeout_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_header_errors();
    send_frag(16'h0000, KIND_START, 0, 1, 8, 1, 1'b0);
    send_frag(16'h0001, 2'd3, 0, 1, 8, 1);
    send_frag(16'h0001, KIND_CONT, 1, 2, 8, 1);
    send_frag(16'h0001, KIND_START, 0, 9, 8, 1);
  endtask

  task automatic test_packets();
    send_frag(16'hFFFF, KIND_START, 0, 1, 64, 8);
    send_frag(16'h0002, KIND_END, 0, 1, 0, 1);
    send_frag(16'h0003, KIND_START, 0, 2, 20, 1);
    send_frag(16'h0003, KIND_CONT, 1, 3, 8, 1);
    send_frag(16'h0003, KIND_CONT, 5, 2, 8, 1);
    send_frag(16'h0003, KIND_CONT, 0, 2, 8, 1);
    send_frag(16'h0003, KIND_END, 1, 2, 65, 1);
    send_frag(16'h0003, KIND_END, 1, 2, 16, 1, 1'b1, 1'b1);
    send_frag(16'h0003, KIND_END, 1, 2, 9, 3);
    send_frag(16'h0003, KIND_END, 0, 1, 8, 0);
    send_item('{req_type: REQ_FRAG, word_first: 1'b0, word_last: 1'b1,
                payload_word: 64'hFFFF_FFFF_FFFF_FFFF, default: '0});
  endtask

  task automatic test_pool_and_clears();
    send_frag(16'h0004, KIND_START, 0, 0, 8, 1);
    for (int p = 5; p <= 8; p++) send_frag(16'(p), KIND_START, 0, 2, 8, 1);
    send_req(REQ_CLR_ONE, 16'h0005);
    send_frag(16'h0008, KIND_START, 0, 2, 8, 1);
    send_req(REQ_CLR_ALL, 16'h0000);
  endtask

  task automatic test_timeouts();
    write_timeout(32'd0);
    send_frag(16'h0009, KIND_START, 0, 2, 8, 1);
    send_frag(16'h000A, KIND_START, 0, 2, 8, 1);
    send_req(REQ_TICK, 16'h0000);
    send_req(REQ_TICK, 16'h0000);
    write_timeout(32'hFFFF_FFFF);
    send_frag(16'h000B, KIND_START, 0, 2, 8, 1);
    repeat (3) send_req(REQ_TICK, 16'h0000);
    send_req(REQ_CLR_ALL, 16'h0000);
  endtask

  task automatic test_random(int unsigned count, logic [31:0] tmo);
    int unsigned plan_total [6];
    int unsigned plan_next [6];
    int unsigned sent;
    int unsigned p, len, nw, r;
    logic [1:0] kind;
    logic [15:0] peer;
    write_timeout(tmo);
    foreach (plan_total[i]) begin
      plan_total[i] = 0;
      plan_next[i] = 0;
    end
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 5);
      peer = 16'h1000 + 16'(p * 16'h1111);
      if (r < 75) begin
        if (plan_next[p] >= plan_total[p]) begin
          plan_total[p] = $urandom_range(1, 4);
          plan_next[p] = 0;
        end
        kind = (plan_next[p] == 0) ? KIND_START :
               (plan_next[p] == plan_total[p] - 1) ? KIND_END : KIND_CONT;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 24);
        nw = (len + 7) / 8;
        if (nw == 0 || $urandom_range(0, 7) == 0) nw = nw + 1;
        else if (nw > 1 && $urandom_range(0, 7) == 0) nw = nw - 1;
        send_frag(peer, kind, plan_next[p], plan_total[p], len, nw);
        if ($urandom_range(0, 9) != 0) plan_next[p]++;
        sent++;
      end else if (r < 85) begin
        send_req(REQ_TICK, 16'h0000);
        sent++;
      end else if (r < 88) begin
        send_req(REQ_CLR_ONE, peer);
      end else if (r < 89) begin
        send_req(REQ_CLR_ALL, 16'h0000);
      end else begin
        send_item(noise_item());
        sent++;
      end
    end
  endtask

  task automatic test_full_queue();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_frag(16'(16'h2000 + i), KIND_END, 0, 1, 8, 1);
  endtask

  initial begin
    timeout_q = TIMEOUT_RESET;
    tick_q = '0;
    asm_active = 1'b0;
    asm_slot = 0;
    asm_seq = 0;
    asm_len = 0;
    asm_words = 0;
    for (int s = 0; s < NSLOT; s++) begin
      sess_busy[s] = 1'b0;
      sess_peer[s] = '0;
      sess_total[s] = 0;
      sess_got[s] = 0;
      sess_start[s] = '0;
      sess_seen[s] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_header_errors();
    test_packets();
    test_pool_and_clears();
    test_timeouts();
    test_random(30, 32'd6);
    test_full_queue();
    test_random(25, 32'd3);
    gaps_on = 1'b0;
    test_random(20, TIMEOUT_RESET);
    drain_all();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS fragment_reassembly_pool");
    end else begin
      $display("FAIL fragment_reassembly_pool");
    end
    $finish;
  end

endmodule
